// ===== rtl/rpn_pkg.sv =====
// ----------------------------------------------------------------------------
// rpn_pkg: shared definitions for the RPN stack calculator
// Opcodes, status codes, the control word layout and the microprogram.
// ----------------------------------------------------------------------------
`default_nettype none

package rpn_pkg;

  localparam int STACK_DEPTH_DEF = 16;

  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_DROP = 3'd1;
  localparam logic [2:0] OP_MIN  = 3'd2;
  localparam logic [2:0] OP_ADD  = 3'd3;
  localparam logic [2:0] OP_SUB  = 3'd4;
  localparam logic [2:0] OP_DIV  = 3'd5;
  localparam logic [2:0] OP_MUL  = 3'd6;
  localparam logic [2:0] OP_NOP  = 3'd7;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FEW     = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_DIVZERO = 3'd4;

  localparam int UPC_W = 5;
  localparam int ITER_W = 5;

  typedef enum logic [4:0] {
    ACT_NONE,
    ACT_ACCEPT,
    ACT_RD_TOP,
    ACT_RD_NEXT_LDB,
    ACT_LDA,
    ACT_ALU,
    ACT_WR_RES,
    ACT_MUL_INIT,
    ACT_MUL_STEP,
    ACT_DIV_INIT,
    ACT_DIV_STEP,
    ACT_DIV_FIX,
    ACT_PUSH,
    ACT_POP,
    ACT_ST_FULL,
    ACT_ST_EMPTY,
    ACT_ST_FEW,
    ACT_ST_DZ,
    ACT_EMIT
  } act_t;

  typedef enum logic [3:0] {
    C_NEXT,
    C_JMP,
    C_IDLE,
    C_OP_PUSH,
    C_OP_DROP,
    C_OP_NOP,
    C_OP_MUL,
    C_OP_DIV,
    C_FULL,
    C_EMPTY,
    C_FEW,
    C_BZERO,
    C_LOOP,
    C_WAIT_OUT
  } cond_t;

  typedef struct packed {
    act_t             act;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } ucode_t;

  localparam logic [UPC_W-1:0] L_IDLE  = 5'd0;
  localparam logic [UPC_W-1:0] L_WR    = 5'd10;
  localparam logic [UPC_W-1:0] L_MUL   = 5'd11;
  localparam logic [UPC_W-1:0] L_MLOOP = 5'd12;
  localparam logic [UPC_W-1:0] L_DIV   = 5'd14;
  localparam logic [UPC_W-1:0] L_DLOOP = 5'd16;
  localparam logic [UPC_W-1:0] L_PUSH  = 5'd18;
  localparam logic [UPC_W-1:0] L_DROP  = 5'd20;
  localparam logic [UPC_W-1:0] L_FULL  = 5'd22;
  localparam logic [UPC_W-1:0] L_EMPTY = 5'd23;
  localparam logic [UPC_W-1:0] L_FEW   = 5'd24;
  localparam logic [UPC_W-1:0] L_DZ    = 5'd25;
  localparam logic [UPC_W-1:0] L_RPT   = 5'd26;

  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
    ucode_t w;
    case (addr)
      5'd0:  w = '{act: ACT_ACCEPT,      cond: C_IDLE,     target: L_IDLE};
      5'd1:  w = '{act: ACT_NONE,        cond: C_OP_PUSH,  target: L_PUSH};
      5'd2:  w = '{act: ACT_NONE,        cond: C_OP_DROP,  target: L_DROP};
      5'd3:  w = '{act: ACT_NONE,        cond: C_OP_NOP,   target: L_RPT};
      5'd4:  w = '{act: ACT_NONE,        cond: C_FEW,      target: L_FEW};
      5'd5:  w = '{act: ACT_RD_TOP,      cond: C_NEXT,     target: L_IDLE};
      5'd6:  w = '{act: ACT_RD_NEXT_LDB, cond: C_NEXT,     target: L_IDLE};
      5'd7:  w = '{act: ACT_LDA,         cond: C_OP_MUL,   target: L_MUL};
      5'd8:  w = '{act: ACT_NONE,        cond: C_OP_DIV,   target: L_DIV};
      5'd9:  w = '{act: ACT_ALU,         cond: C_NEXT,     target: L_IDLE};
      5'd10: w = '{act: ACT_WR_RES,      cond: C_JMP,      target: L_RPT};
      5'd11: w = '{act: ACT_MUL_INIT,    cond: C_NEXT,     target: L_IDLE};
      5'd12: w = '{act: ACT_MUL_STEP,    cond: C_LOOP,     target: L_MLOOP};
      5'd13: w = '{act: ACT_NONE,        cond: C_JMP,      target: L_WR};
      5'd14: w = '{act: ACT_NONE,        cond: C_BZERO,    target: L_DZ};
      5'd15: w = '{act: ACT_DIV_INIT,    cond: C_NEXT,     target: L_IDLE};
      5'd16: w = '{act: ACT_DIV_STEP,    cond: C_LOOP,     target: L_DLOOP};
      5'd17: w = '{act: ACT_DIV_FIX,     cond: C_JMP,      target: L_WR};
      5'd18: w = '{act: ACT_NONE,        cond: C_FULL,     target: L_FULL};
      5'd19: w = '{act: ACT_PUSH,        cond: C_JMP,      target: L_RPT};
      5'd20: w = '{act: ACT_NONE,        cond: C_EMPTY,    target: L_EMPTY};
      5'd21: w = '{act: ACT_POP,         cond: C_JMP,      target: L_RPT};
      5'd22: w = '{act: ACT_ST_FULL,     cond: C_JMP,      target: L_RPT};
      5'd23: w = '{act: ACT_ST_EMPTY,    cond: C_JMP,      target: L_RPT};
      5'd24: w = '{act: ACT_ST_FEW,      cond: C_JMP,      target: L_RPT};
      5'd25: w = '{act: ACT_ST_DZ,       cond: C_JMP,      target: L_RPT};
      5'd26: w = '{act: ACT_RD_TOP,      cond: C_NEXT,     target: L_IDLE};
      5'd27: w = '{act: ACT_EMIT,        cond: C_WAIT_OUT, target: L_IDLE};
      default: w = '{act: ACT_NONE,      cond: C_JMP,      target: L_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rpn_stack_mem.sv =====
// ----------------------------------------------------------------------------
// rpn_stack_mem: stack storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_stack_mem #(
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [31:0]              wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [31:0]              rd_data
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rpn_stack_calculator.sv =====
// ----------------------------------------------------------------------------
// rpn_stack_calculator: reverse-Polish integer calculator on a bounded stack
// A microcoded sequencer steps a small datapath through each command and
// reports status, top of stack and depth.
// ----------------------------------------------------------------------------
//   Channel  Direction  Ports                                      Handshake
//   in       input      in_opcode, in_push_value                   in_valid/in_stall
//   out      output     out_status, out_top_value, out_stack_depth out_valid/out_stall
//
// Push, no-op, a full stack, drop, an empty drop, too few operands, min, add,
// subtract and a zero divisor each run a short microcode path; multiply and
// divide run the 32 steps of a shift-add loop and of a restoring-division
// loop, and operands come through the registered stack read port.
// Reset clears the step counter, the entry count and the output valid.
// A new transaction is taken only when the step counter is at its idle step.
// A stalled result holds in the output register while the next command runs.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_stack_calculator #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic        [2:0]  in_opcode,
  input  wire logic signed [31:0] in_push_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic             [2:0]  out_status,
  output logic signed      [31:0] out_top_value,
  output logic             [4:0]  out_stack_depth
);

  import rpn_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [UPC_W-1:0]  upc_r, upc_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [2:0]        op_r, op_nxt;
  logic [31:0]       val_r, val_nxt;
  logic [2:0]        status_r, status_nxt;
  logic [31:0]       a_r, a_nxt;
  logic [31:0]       b_r, b_nxt;
  logic [31:0]       acc_r, acc_nxt;
  logic              neg_r, neg_nxt;
  logic [ITER_W-1:0] itr_r, itr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        out_status_r, out_status_nxt;
  logic [31:0]       out_top_r, out_top_nxt;
  logic [4:0]        out_depth_r, out_depth_nxt;

  ucode_t      uw;
  logic        in_fire;
  logic        out_busy;
  logic        take;
  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] cnt_m2;
  logic [CW+4:0] cnt_ext;
  logic [32:0] rem_sh;
  logic [32:0] rem_diff;

  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [31:0]   mem_wr_data;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic [31:0]   mem_rd_data;

  rpn_stack_mem #(
    .DEPTH (STACK_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign uw       = ucode_rom(upc_r);
  assign in_stall = (upc_r != L_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_busy = out_valid_r && out_stall;
  assign cnt_m1   = cnt_r - CW'(1);
  assign cnt_m2   = cnt_r - CW'(2);
  assign cnt_ext  = {5'd0, cnt_r};
  assign rem_sh   = {acc_r, a_r[31]};
  assign rem_diff = rem_sh - {1'b0, b_r};

  always_comb begin
    case (uw.cond)
      C_NEXT:    take = 1'b0;
      C_JMP:     take = 1'b1;
      C_IDLE:    take = !in_fire;
      C_OP_PUSH: take = (op_r == OP_PUSH);
      C_OP_DROP: take = (op_r == OP_DROP);
      C_OP_NOP:  take = (op_r == OP_NOP);
      C_OP_MUL:  take = (op_r == OP_MUL);
      C_OP_DIV:  take = (op_r == OP_DIV);
      C_FULL:    take = (cnt_r >= CW'(STACK_DEPTH));
      C_EMPTY:   take = (cnt_r == '0);
      C_FEW:     take = (cnt_r < CW'(2));
      C_BZERO:   take = (b_r == 32'd0);
      C_LOOP:    take = (itr_r != '0);
      C_WAIT_OUT: take = !out_busy;
      default:   take = 1'b0;
    endcase
  end

  always_comb begin
    upc_nxt        = take ? uw.target : upc_r + UPC_W'(1);
    if ((uw.cond == C_WAIT_OUT) && out_busy) begin
      upc_nxt = upc_r;
    end
    cnt_nxt        = cnt_r;
    op_nxt         = op_r;
    val_nxt        = val_r;
    status_nxt     = status_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    acc_nxt        = acc_r;
    neg_nxt        = neg_r;
    itr_nxt        = itr_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_top_nxt    = out_top_r;
    out_depth_nxt  = out_depth_r;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = cnt_m2[AW-1:0];
    mem_wr_data    = acc_r;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = cnt_m1[AW-1:0];

    case (uw.act)
      ACT_NONE: begin
      end
      ACT_ACCEPT: begin
        if (in_fire) begin
          op_nxt     = in_opcode;
          val_nxt    = in_push_value;
          status_nxt = ST_OK;
        end
      end
      ACT_RD_TOP: begin
        mem_rd_en = 1'b1;
      end
      ACT_RD_NEXT_LDB: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = cnt_m2[AW-1:0];
        b_nxt       = mem_rd_data;
      end
      ACT_LDA: begin
        a_nxt = mem_rd_data;
      end
      ACT_ALU: begin
        case (op_r)
          OP_MIN:  acc_nxt = ($signed(a_r) < $signed(b_r)) ? a_r : b_r;
          OP_ADD:  acc_nxt = a_r + b_r;
          OP_SUB:  acc_nxt = a_r - b_r;
          default: acc_nxt = a_r;
        endcase
      end
      ACT_WR_RES: begin
        mem_wr_en = 1'b1;
        cnt_nxt   = cnt_m1;
      end
      ACT_MUL_INIT: begin
        acc_nxt = '0;
        itr_nxt = ITER_W'(31);
      end
      ACT_MUL_STEP: begin
        acc_nxt = b_r[0] ? acc_r + a_r : acc_r;
        a_nxt   = {a_r[30:0], 1'b0};
        b_nxt   = {1'b0, b_r[31:1]};
        itr_nxt = itr_r - ITER_W'(1);
      end
      ACT_DIV_INIT: begin
        a_nxt   = a_r[31] ? (32'd0 - a_r) : a_r;
        b_nxt   = b_r[31] ? (32'd0 - b_r) : b_r;
        neg_nxt = a_r[31] ^ b_r[31];
        acc_nxt = '0;
        itr_nxt = ITER_W'(31);
      end
      ACT_DIV_STEP: begin
        acc_nxt = rem_diff[32] ? rem_sh[31:0] : rem_diff[31:0];
        a_nxt   = {a_r[30:0], !rem_diff[32]};
        itr_nxt = itr_r - ITER_W'(1);
      end
      ACT_DIV_FIX: begin
        acc_nxt = neg_r ? (32'd0 - a_r) : a_r;
      end
      ACT_PUSH: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = cnt_r[AW-1:0];
        mem_wr_data = val_r;
        cnt_nxt     = cnt_r + CW'(1);
      end
      ACT_POP: begin
        cnt_nxt = cnt_m1;
      end
      ACT_ST_FULL:  status_nxt = ST_FULL;
      ACT_ST_EMPTY: status_nxt = ST_EMPTY;
      ACT_ST_FEW:   status_nxt = ST_FEW;
      ACT_ST_DZ:    status_nxt = ST_DIVZERO;
      ACT_EMIT: begin
        if (!out_busy) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_top_nxt    = (cnt_r == '0) ? 32'd0 : mem_rd_data;
          out_depth_nxt  = cnt_ext[4:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= L_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    val_r        <= val_nxt;
    status_r     <= status_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    acc_r        <= acc_nxt;
    neg_r        <= neg_nxt;
    itr_r        <= itr_nxt;
    out_status_r <= out_status_nxt;
    out_top_r    <= out_top_nxt;
    out_depth_r  <= out_depth_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_top_value   = out_top_r;
  assign out_stack_depth = out_depth_r;

endmodule

`default_nettype wire
